[design/kmp_pkg.sv]
`timescale 1ns / 1ps

package kmp_pkg;

  localparam int MaxPattern = 64;
  localparam int PidxW      = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int PosW       = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_NOMATCH  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic            done;
    logic [LenW-1:0] next_j;
  } cmp_res_t;

endpackage

[design/kmp_in_if.sv]
`timescale 1ns / 1ps

interface kmp_in_if import kmp_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] char_byte;
  logic       text_last;

  modport source (output valid, output op, output char_byte, output text_last, input ready);
  modport sink (input valid, input op, input char_byte, input text_last, output ready);
endinterface

[design/kmp_out_if.sv]
`timescale 1ns / 1ps

interface kmp_out_if import kmp_pkg::*;;
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic [PosW-1:0] match_position;

  modport source (output valid, output status, output match_position, input ready);
  modport sink (input valid, input status, input match_position, output ready);
endinterface

[design/kmp_ram.sv]
`timescale 1ns / 1ps

module kmp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/kmp_cmp.sv]
`timescale 1ns / 1ps

module kmp_cmp import kmp_pkg::*; (
  input  logic [LenW-1:0] j_i,
  input  logic [7:0]      pat_byte_i,
  input  logic [7:0]      char_i,
  input  logic [LenW-1:0] fail_link_i,
  output cmp_res_t        res_o
);

  logic hit;
  logic at_root;

  assign hit     = (pat_byte_i == char_i);
  assign at_root = (j_i == '0);

  always_comb begin
    res_o.done   = hit || at_root;
    // mismatch at the root falls to -1, which plus one is zero
    if (hit) begin
      res_o.next_j = j_i + LenW'(1);
    end else if (at_root) begin
      res_o.next_j = '0;
    end else begin
      res_o.next_j = fail_link_i;
    end
  end

endmodule

[design/kmp_substring_search.sv]
`timescale 1ns / 1ps

// KMP first-occurrence substring search.
// in_i carries one item per handshake: op (clear, append pattern byte,
// text byte, no-op), char_byte and text_last. out_o carries at most one
// result per search: status and match_position.
// Clear, append with the pattern full, the first append after a clear,
// no-op and text after the search is done are handled on acceptance and
// leave the block ready. Any other append or text byte walks the failure
// links through one shared compare unit fed by two registered-read RAMs
// (pattern bytes and failure links): the byte is accepted, then compares
// run one after another, one per fallback taken plus the last. Amortized
// over a stream this is about 2 compares per byte.
// A result is written into the result register after the last compare
// and moves through the emit state into the output register, and a text
// byte that meets an overflowed or empty pattern goes straight to the emit
// state; in_i stays not ready until the output register is free, so a
// stalled receiver holds the block once a new result is ready.
// Reset clears length, link and match state and the output valid flag;
// the RAMs are not cleared, only written entries are ever used.
module kmp_substring_search import kmp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  kmp_in_if.sink    in_i,
  kmp_out_if.source out_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COMP = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] bpi_q, bpi_d;
  logic            bpi_neg_q, bpi_neg_d;
  logic [LenW-1:0] mi_q, mi_d;
  logic [PosW-1:0] tp_q, tp_d;
  logic            done_q, done_d;
  logic            ovf_q, ovf_d;
  logic [LenW-1:0] j_q, j_d;
  logic            build_q, build_d;
  logic            last_q, last_d;
  logic [7:0]      c_q, c_d;
  logic [1:0]      res_st_q, res_st_d;
  logic [PosW-1:0] res_pos_q, res_pos_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_st_q, out_st_d;
  logic [PosW-1:0] out_pos_q, out_pos_d;

  logic            accept;
  logic [LenW-1:0] rd_j;
  logic            pat_we;
  logic            fail_we;
  logic [LenW-1:0] fail_wdata;
  logic [7:0]      pat_rdata;
  logic [LenW-1:0] fail_rdata;
  logic [LenW-1:0] len_inc;
  logic [PosW-1:0] tp_inc;
  cmp_res_t        cmp;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign len_inc    = len_q + LenW'(1);
  assign tp_inc     = (tp_q != '1) ? tp_q + PosW'(1) : tp_q;

  kmp_ram #(.Width(8), .Depth(MaxPattern)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (len_q[PidxW-1:0]),
    .wdata_i (in_i.char_byte),
    .raddr_i (rd_j[PidxW-1:0]),
    .rdata_o (pat_rdata)
  );

  kmp_ram #(.Width(LenW), .Depth(MaxPattern + 1)) u_fail_ram (
    .clk_i   (clk_i),
    .we_i    (fail_we),
    .waddr_i (len_inc),
    .wdata_i (fail_wdata),
    .raddr_i (rd_j),
    .rdata_o (fail_rdata)
  );

  kmp_cmp u_cmp (
    .j_i         (j_q),
    .pat_byte_i  (pat_rdata),
    .char_i      (c_q),
    .fail_link_i (fail_rdata),
    .res_o       (cmp)
  );

  always_comb begin
    if (state_q == S_IDLE) begin
      rd_j = (op_e'(in_i.op) == OP_APPEND) ? bpi_q : mi_q;
    end else begin
      rd_j = cmp.next_j;
    end
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    bpi_d       = bpi_q;
    bpi_neg_d   = bpi_neg_q;
    mi_d        = mi_q;
    tp_d        = tp_q;
    done_d      = done_q;
    ovf_d       = ovf_q;
    j_d         = j_q;
    build_d     = build_q;
    last_d      = last_q;
    c_d         = c_q;
    res_st_d    = res_st_q;
    res_pos_d   = res_pos_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_st_d    = out_st_q;
    out_pos_d   = out_pos_q;
    pat_we      = 1'b0;
    fail_we     = 1'b0;
    fail_wdata  = cmp.next_j;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          c_d    = in_i.char_byte;
          last_d = in_i.text_last;
          j_d    = rd_j;
          case (op_e'(in_i.op))
            OP_CLEAR: begin
              len_d     = '0;
              bpi_d     = '0;
              bpi_neg_d = 1'b1;
              mi_d      = '0;
              tp_d      = '0;
              done_d    = 1'b0;
              ovf_d     = 1'b0;
            end
            OP_APPEND: begin
              if (len_q >= LenW'(MaxPattern)) begin
                ovf_d = 1'b1;
              end else begin
                pat_we  = 1'b1;
                build_d = 1'b1;
                if (bpi_neg_q) begin
                  fail_we    = 1'b1;
                  fail_wdata = '0;
                  bpi_d      = '0;
                  bpi_neg_d  = 1'b0;
                  len_d      = len_inc;
                end else begin
                  state_d = S_COMP;
                end
              end
            end
            OP_TEXT: begin
              if (!done_q) begin
                build_d = 1'b0;
                if (ovf_q) begin
                  done_d    = 1'b1;
                  res_st_d  = ST_OVERFLOW;
                  res_pos_d = '0;
                  state_d   = S_EMIT;
                end else if (len_q == '0) begin
                  done_d    = 1'b1;
                  res_st_d  = ST_MATCH;
                  res_pos_d = '0;
                  state_d   = S_EMIT;
                end else begin
                  state_d = S_COMP;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_COMP: begin
        if (!cmp.done) begin
          j_d = cmp.next_j;
        end else if (build_q) begin
          fail_we = 1'b1;
          bpi_d   = cmp.next_j;
          len_d   = len_inc;
          state_d = S_IDLE;
        end else begin
          tp_d = tp_inc;
          if (cmp.next_j >= len_q) begin
            done_d    = 1'b1;
            mi_d      = '0;
            res_st_d  = ST_MATCH;
            res_pos_d = tp_q + PosW'(1) - PosW'(len_q);
            state_d   = S_EMIT;
          end else begin
            mi_d = cmp.next_j;
            if (last_q) begin
              done_d    = 1'b1;
              res_st_d  = ST_NOMATCH;
              res_pos_d = '0;
              state_d   = S_EMIT;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_pos_d   = res_pos_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      bpi_q       <= '0;
      bpi_neg_q   <= 1'b1;
      mi_q        <= '0;
      tp_q        <= '0;
      done_q      <= 1'b0;
      ovf_q       <= 1'b0;
      build_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      bpi_q       <= bpi_d;
      bpi_neg_q   <= bpi_neg_d;
      mi_q        <= mi_d;
      tp_q        <= tp_d;
      done_q      <= done_d;
      ovf_q       <= ovf_d;
      build_q     <= build_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q       <= j_d;
    last_q    <= last_d;
    c_q       <= c_d;
    res_st_q  <= res_st_d;
    res_pos_q <= res_pos_d;
    out_st_q  <= out_st_d;
    out_pos_q <= out_pos_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_st_q;
  assign out_o.match_position = out_pos_q;

endmodule
